// ===== rtl/core/hsb_to_rgb_converter_unit_assert.svh =====
// ----------------------------------------------------------------------------
// HSB to RGB converter assertion macros
// Shared property forms for the port-level checker.
// ----------------------------------------------------------------------------
`ifndef HSB_TO_RGB_CONVERTER_UNIT_ASSERT_SVH
`define HSB_TO_RGB_CONVERTER_UNIT_ASSERT_SVH

// same-cycle implication, checked on clk, idle during reset
`define HSBRGB_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("hsbrgb: same-cycle check failed");

// next-cycle implication, checked on clk, idle during reset
`define HSBRGB_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("hsbrgb: next-cycle check failed");

`endif

// ===== rtl/core/hsbrgb_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// HSB to RGB converter package
// Widths, constants and shared types of the converter pipeline.
// ----------------------------------------------------------------------------
package hsbrgb_pkg;

	localparam int HUE_W = 9;
	localparam int PCT_W = 7;
	localparam int CH_W  = 8;
	localparam int REM_W = 6;
	localparam int TRM_W = 13;
	localparam int B17_W = 11;
	localparam int B51_W = 13;
	localparam int MUL_W = 9;

	localparam int HUE_LIMIT  = 360;
	localparam int PCT_LIMIT  = 100;
	localparam int SECTOR_DEG = 60;
	localparam int FULL_TERM  = PCT_LIMIT * SECTOR_DEG;

	// 255/600000 = 17/40000, 255/10000 = 51/2000, 255/100 = 51/20
	localparam int QT_NUM = 17;
	localparam int P_NUM  = 51;

	localparam int XQT_W  = 24;
	localparam int QT_DIV = 40000;
	localparam int QT_MUL = (1 << XQT_W) / QT_DIV;

	localparam int XP_W   = 19;
	localparam int P_DIV  = 2000;
	localparam int P_MUL  = (1 << XP_W) / P_DIV;

	localparam int XV_W   = 13;
	localparam int V_DIV  = 20;
	localparam int V_MUL  = (1 << XV_W) / V_DIV;

	typedef enum logic [2:0] {
		SEC_R_Y = 3'd0,
		SEC_Y_G = 3'd1,
		SEC_G_C = 3'd2,
		SEC_C_B = 3'd3,
		SEC_B_M = 3'd4,
		SEC_M_R = 3'd5
	} sector_t;

	typedef struct packed {
		logic    valid;
		sector_t sector;
	} ctl_t;

endpackage

// ===== rtl/core/hsbrgb_sector.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// HSB to RGB sector stage
// Clamps the inputs, finds the hue sector and the offset inside it.
// ----------------------------------------------------------------------------
module hsbrgb_sector
	import hsbrgb_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               en,
	input  logic               in_valid,
	input  logic [HUE_W-1:0]   hue,
	input  logic [PCT_W-1:0]   saturation,
	input  logic [PCT_W-1:0]   brightness,
	output ctl_t               ctl_s1,
	output logic [REM_W-1:0]   rem_s1,
	output logic [PCT_W-1:0]   sat_s1,
	output logic [PCT_W-1:0]   bri_s1
);

	logic [HUE_W-1:0] hue_c;
	logic [HUE_W-1:0] base_c;
	logic [HUE_W-1:0] off_c;
	sector_t          sec_c;
	logic [PCT_W-1:0] sat_c;
	logic [PCT_W-1:0] bri_c;

	always_comb begin
		hue_c = (hue > HUE_W'(HUE_LIMIT)) ? HUE_W'(HUE_LIMIT) : hue;
		sat_c = (saturation > PCT_W'(PCT_LIMIT)) ? PCT_W'(PCT_LIMIT) : saturation;
		bri_c = (brightness > PCT_W'(PCT_LIMIT)) ? PCT_W'(PCT_LIMIT) : brightness;
		// full turn wraps to the first sector
		priority if (hue_c >= HUE_W'(HUE_LIMIT)) begin
			sec_c  = SEC_R_Y;
			base_c = HUE_W'(HUE_LIMIT);
		end else if (hue_c >= HUE_W'(5 * SECTOR_DEG)) begin
			sec_c  = SEC_M_R;
			base_c = HUE_W'(5 * SECTOR_DEG);
		end else if (hue_c >= HUE_W'(4 * SECTOR_DEG)) begin
			sec_c  = SEC_B_M;
			base_c = HUE_W'(4 * SECTOR_DEG);
		end else if (hue_c >= HUE_W'(3 * SECTOR_DEG)) begin
			sec_c  = SEC_C_B;
			base_c = HUE_W'(3 * SECTOR_DEG);
		end else if (hue_c >= HUE_W'(2 * SECTOR_DEG)) begin
			sec_c  = SEC_G_C;
			base_c = HUE_W'(2 * SECTOR_DEG);
		end else if (hue_c >= HUE_W'(SECTOR_DEG)) begin
			sec_c  = SEC_Y_G;
			base_c = HUE_W'(SECTOR_DEG);
		end else begin
			sec_c  = SEC_R_Y;
			base_c = '0;
		end
		off_c = hue_c - base_c;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
		end else if (en) begin
			ctl_s1.valid  <= in_valid;
			ctl_s1.sector <= sec_c;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_s1        <= off_c[REM_W-1:0];
			sat_s1        <= sat_c;
			bri_s1        <= bri_c;
		end
	end

endmodule

// ===== rtl/core/hsbrgb_terms.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// HSB to RGB term stages
// Forms the p, q, t and v numerators scaled to the channel range.
// ----------------------------------------------------------------------------
module hsbrgb_terms
	import hsbrgb_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               en,
	input  ctl_t               ctl_s1,
	input  logic [REM_W-1:0]   rem_s1,
	input  logic [PCT_W-1:0]   sat_s1,
	input  logic [PCT_W-1:0]   bri_s1,
	output ctl_t               ctl_s3,
	output logic [XQT_W-1:0]   xq_s3,
	output logic [XQT_W-1:0]   xt_s3,
	output logic [XP_W-1:0]    xp_s3,
	output logic [XV_W-1:0]    xv_s3
);

	ctl_t             ctl_s2;
	logic [TRM_W-1:0] nq_s2;
	logic [TRM_W-1:0] nt_s2;
	logic [PCT_W-1:0] np_s2;
	logic [B17_W-1:0] b17_s2;
	logic [B51_W-1:0] b51_s2;

	logic [REM_W-1:0] rem_inv_c;
	logic [TRM_W-1:0] prod_q_c;
	logic [TRM_W-1:0] prod_t_c;
	logic [XP_W:0]    prod_p_c;

	always_comb begin
		rem_inv_c = REM_W'(SECTOR_DEG) - rem_s1;
		prod_q_c  = TRM_W'(rem_s1) * TRM_W'(sat_s1);
		prod_t_c  = TRM_W'(rem_inv_c) * TRM_W'(sat_s1);
		prod_p_c  = (XP_W+1)'(b51_s2) * (XP_W+1)'(np_s2);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s2 <= '0;
			ctl_s3 <= '0;
		end else if (en) begin
			ctl_s2 <= ctl_s1;
			ctl_s3 <= ctl_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			nq_s2         <= TRM_W'(FULL_TERM) - prod_q_c;
			nt_s2         <= TRM_W'(FULL_TERM) - prod_t_c;
			np_s2         <= PCT_W'(PCT_LIMIT) - sat_s1;
			b17_s2        <= B17_W'(QT_NUM) * B17_W'(bri_s1);
			b51_s2        <= B51_W'(P_NUM) * B51_W'(bri_s1);

			xq_s3         <= XQT_W'(b17_s2) * XQT_W'(nq_s2);
			xt_s3         <= XQT_W'(b17_s2) * XQT_W'(nt_s2);
			xp_s3         <= prod_p_c[XP_W-1:0];
			xv_s3         <= b51_s2;
		end
	end

endmodule

// ===== rtl/core/hsbrgb_scale.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// HSB to RGB scale stages
// Divides by constants via reciprocal and correction, maps sector to channels.
// ----------------------------------------------------------------------------
module hsbrgb_scale
	import hsbrgb_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               en,
	input  ctl_t               ctl_s3,
	input  logic [XQT_W-1:0]   xq_s3,
	input  logic [XQT_W-1:0]   xt_s3,
	input  logic [XP_W-1:0]    xp_s3,
	input  logic [XV_W-1:0]    xv_s3,
	output logic               out_valid,
	output logic [CH_W-1:0]    red,
	output logic [CH_W-1:0]    green,
	output logic [CH_W-1:0]    blue
);

	localparam int PQT_W = XQT_W + MUL_W;
	localparam int PP_W  = XP_W + MUL_W;
	localparam int PV_W  = XV_W + MUL_W;

	ctl_t             ctl_s4;
	logic [XQT_W-1:0] xq_s4;
	logic [XQT_W-1:0] xt_s4;
	logic [XP_W-1:0]  xp_s4;
	logic [XV_W-1:0]  xv_s4;
	logic [CH_W-1:0]  eq_s4;
	logic [CH_W-1:0]  et_s4;
	logic [CH_W-1:0]  ep_s4;
	logic [CH_W-1:0]  ev_s4;

	logic [PQT_W-1:0] mq_c;
	logic [PQT_W-1:0] mt_c;
	logic [PP_W-1:0]  mp_c;
	logic [PV_W-1:0]  mv_c;

	logic [XQT_W-1:0] rq_c;
	logic [XQT_W-1:0] rt_c;
	logic [XP_W-1:0]  rp_c;
	logic [XV_W-1:0]  rv_c;
	logic [CH_W-1:0]  cq_c;
	logic [CH_W-1:0]  ct_c;
	logic [CH_W-1:0]  cp_c;
	logic [CH_W-1:0]  cv_c;
	logic [CH_W-1:0]  red_c;
	logic [CH_W-1:0]  green_c;
	logic [CH_W-1:0]  blue_c;

	// estimates never exceed the exact quotient and trail it by at most one
	always_comb begin
		mq_c = PQT_W'(xq_s3) * PQT_W'(QT_MUL);
		mt_c = PQT_W'(xt_s3) * PQT_W'(QT_MUL);
		mp_c = PP_W'(xp_s3) * PP_W'(P_MUL);
		mv_c = PV_W'(xv_s3) * PV_W'(V_MUL);
	end

	always_comb begin
		rq_c = xq_s4 - XQT_W'(eq_s4) * XQT_W'(QT_DIV);
		rt_c = xt_s4 - XQT_W'(et_s4) * XQT_W'(QT_DIV);
		rp_c = xp_s4 - XP_W'(ep_s4) * XP_W'(P_DIV);
		rv_c = xv_s4 - XV_W'(ev_s4) * XV_W'(V_DIV);
		cq_c = (rq_c >= XQT_W'(QT_DIV)) ? eq_s4 + CH_W'(1) : eq_s4;
		ct_c = (rt_c >= XQT_W'(QT_DIV)) ? et_s4 + CH_W'(1) : et_s4;
		cp_c = (rp_c >= XP_W'(P_DIV)) ? ep_s4 + CH_W'(1) : ep_s4;
		cv_c = (rv_c >= XV_W'(V_DIV)) ? ev_s4 + CH_W'(1) : ev_s4;
		unique case (ctl_s4.sector)
			SEC_R_Y: begin
				red_c = cv_c; green_c = ct_c; blue_c = cp_c;
			end
			SEC_Y_G: begin
				red_c = cq_c; green_c = cv_c; blue_c = cp_c;
			end
			SEC_G_C: begin
				red_c = cp_c; green_c = cv_c; blue_c = ct_c;
			end
			SEC_C_B: begin
				red_c = cp_c; green_c = cq_c; blue_c = cv_c;
			end
			SEC_B_M: begin
				red_c = ct_c; green_c = cp_c; blue_c = cv_c;
			end
			default: begin
				red_c = cv_c; green_c = cp_c; blue_c = cq_c;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s4    <= '0;
			out_valid <= 1'b0;
		end else if (en) begin
			ctl_s4    <= ctl_s3;
			out_valid <= ctl_s4.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			xq_s4         <= xq_s3;
			xt_s4         <= xt_s3;
			xp_s4         <= xp_s3;
			xv_s4         <= xv_s3;
			eq_s4         <= mq_c[XQT_W +: CH_W];
			et_s4         <= mt_c[XQT_W +: CH_W];
			ep_s4         <= mp_c[XP_W +: CH_W];
			ev_s4         <= mv_c[XV_W +: CH_W];
			red           <= red_c;
			green         <= green_c;
			blue          <= blue_c;
		end
	end

endmodule

// ===== rtl/core/hsb_to_rgb_converter_unit.sv =====
`timescale 1ns / 1ps
// Throughput: one item per clock while not stalled; the five register stages advance together.
// Output stall holds the whole pipeline and is reflected on in_stall.
// Reset clears only the stage valid bits and sector codes; no clearing pass.
// ----------------------------------------------------------------------------
// HSB to RGB converter
// Hue/saturation/brightness to 8-bit RGB, six-sector rule, exact truncation.
// ----------------------------------------------------------------------------
module hsb_to_rgb_converter_unit
	import hsbrgb_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_stall,
	input  logic [HUE_W-1:0] hue,
	input  logic [PCT_W-1:0] saturation,
	input  logic [PCT_W-1:0] brightness,
	output logic             out_valid,
	input  logic             out_stall,
	output logic [CH_W-1:0]  red,
	output logic [CH_W-1:0]  green,
	output logic [CH_W-1:0]  blue
);

	logic             en;
	ctl_t             ctl_s1;
	ctl_t             ctl_s3;
	logic [REM_W-1:0] rem_s1;
	logic [PCT_W-1:0] sat_s1;
	logic [PCT_W-1:0] bri_s1;
	logic [XQT_W-1:0] xq_s3;
	logic [XQT_W-1:0] xt_s3;
	logic [XP_W-1:0]  xp_s3;
	logic [XV_W-1:0]  xv_s3;

	assign en       = !(out_valid && out_stall);
	assign in_stall = !en;

	hsbrgb_sector u_sector (
		.clk        (clk),
		.arst_n     (arst_n),
		.en         (en),
		.in_valid   (in_valid),
		.hue        (hue),
		.saturation (saturation),
		.brightness (brightness),
		.ctl_s1     (ctl_s1),
		.rem_s1     (rem_s1),
		.sat_s1     (sat_s1),
		.bri_s1     (bri_s1)
	);

	hsbrgb_terms u_terms (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.ctl_s1 (ctl_s1),
		.rem_s1 (rem_s1),
		.sat_s1 (sat_s1),
		.bri_s1 (bri_s1),
		.ctl_s3 (ctl_s3),
		.xq_s3  (xq_s3),
		.xt_s3  (xt_s3),
		.xp_s3  (xp_s3),
		.xv_s3  (xv_s3)
	);

	hsbrgb_scale u_scale (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.ctl_s3    (ctl_s3),
		.xq_s3     (xq_s3),
		.xt_s3     (xt_s3),
		.xp_s3     (xp_s3),
		.xv_s3     (xv_s3),
		.out_valid (out_valid),
		.red       (red),
		.green     (green),
		.blue      (blue)
	);

endmodule

// ===== rtl/core/hsbrgb_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// HSB to RGB converter checker
// Port-level properties of the converter, bound to the top level.
// ----------------------------------------------------------------------------
`include "hsb_to_rgb_converter_unit_assert.svh"

module hsbrgb_checker
	import hsbrgb_pkg::*;
(
	input logic             clk,
	input logic             arst_n,
	input logic             in_valid,
	input logic             in_stall,
	input logic [PCT_W-1:0] saturation,
	input logic [PCT_W-1:0] brightness,
	input logic             out_valid,
	input logic             out_stall,
	input logic [CH_W-1:0]  red,
	input logic [CH_W-1:0]  green,
	input logic [CH_W-1:0]  blue
);

	`HSBRGB_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(red) && $stable(green) && $stable(blue))
	`HSBRGB_ASSERT_NOW(a_backpressure, 1'b1, in_stall == (out_valid && out_stall))
	`HSBRGB_ASSERT_NEXT(a_dark, in_valid && !in_stall && brightness == 7'd0 ##1 !out_stall ##1 !out_stall ##1 !out_stall ##1 !out_stall, out_valid && red == 8'd0 && green == 8'd0 && blue == 8'd0)
	`HSBRGB_ASSERT_NEXT(a_gray, in_valid && !in_stall && saturation == 7'd0 ##1 !out_stall ##1 !out_stall ##1 !out_stall ##1 !out_stall, out_valid && red == green && green == blue)

endmodule

bind hsb_to_rgb_converter_unit hsbrgb_checker u_checker (.*);
